// File: hw/rtl/itoa_pkg.sv
// Shared types, codes and the digit table of the integer to ASCII formatter.
// Used by itoa_ctrl, itoa_datapath and integer_to_ascii_formatter.
// Depends on nothing.
package itoa_pkg;

    localparam int VALUE_W     = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int MAX_DIGITS  = 11;
    localparam int DIGIT_IDX_W = 4;
    localparam int STEP_CNT_W  = 5;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_BAD = 2'd3;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(VALUE_W - 1);

    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_FIND,
        ST_MINUS,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic dd_step;
        logic find;
        logic emit_minus;
        logic emit_digit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dd_last;
        logic minus;
        logic idx_zero;
    } dp_status_t;

    typedef logic [3:0] digit_vec_t [MAX_DIGITS];

    // ASCII for one digit value: '0'..'9' then uppercase 'A'..'F'.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'd0, d};
        end
        else
        begin
            c = 8'h37 + {4'd0, d};
        end
        return c;
    endfunction

    // Position of the most significant nonzero digit, or zero when all are zero.
    function automatic logic [DIGIT_IDX_W-1:0] lead_digit(input digit_vec_t v);
        logic [DIGIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (v[i] != 4'd0)
            begin
                idx = DIGIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/itoa_ctrl.sv
// Controller state machine of the integer to ASCII formatter.
// Issues commands to itoa_datapath and reads its status; depends on itoa_pkg.
module itoa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            radix_code,
    input  itoa_pkg::dp_status_t  status,
    output itoa_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);

    itoa_pkg::state_t state_reg;
    itoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (radix_code == itoa_pkg::RADIX_DEC)
                    begin
                        state_next = itoa_pkg::ST_CONVERT;
                    end
                    else if (radix_code != itoa_pkg::RADIX_BAD)
                    begin
                        state_next = itoa_pkg::ST_FIND;
                    end
                end
            end
            itoa_pkg::ST_CONVERT:
            begin
                if (status.dd_last)
                begin
                    state_next = itoa_pkg::ST_FIND;
                end
            end
            itoa_pkg::ST_FIND:
            begin
                state_next = status.minus ? itoa_pkg::ST_MINUS : itoa_pkg::ST_DIGITS;
            end
            itoa_pkg::ST_MINUS:
            begin
                state_next = itoa_pkg::ST_DIGITS;
            end
            itoa_pkg::ST_DIGITS:
            begin
                if (status.idx_zero)
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                // A request with the unused radix code is taken and dropped.
                cmd.load = start && (radix_code != itoa_pkg::RADIX_BAD);
            end
            itoa_pkg::ST_CONVERT:
            begin
                cmd.dd_step = 1'b1;
            end
            itoa_pkg::ST_FIND:
            begin
                cmd.find = 1'b1;
            end
            itoa_pkg::ST_MINUS:
            begin
                cmd.emit_minus = 1'b1;
            end
            itoa_pkg::ST_DIGITS:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/itoa_datapath.sv
// Datapath of the integer to ASCII formatter: operand registers, a
// shift-and-add-3 binary to BCD converter and the character output register.
// Depends on itoa_pkg.
module itoa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [31:0]   value,
    input  logic [1:0]           radix_code,
    input  itoa_pkg::ctrl_cmd_t  cmd,
    output itoa_pkg::dp_status_t status,
    output logic                 char_valid,
    output logic [7:0]           char_code,
    output logic                 last_char
);

    localparam int BCD_W = 4 * itoa_pkg::BCD_DIGITS;

    logic [itoa_pkg::VALUE_W-1:0]      mag_reg,   mag_next;
    logic [BCD_W-1:0]                  bcd_reg,   bcd_next;
    logic [1:0]                        radix_reg, radix_next;
    logic                              minus_reg, minus_next;
    logic [itoa_pkg::STEP_CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [itoa_pkg::DIGIT_IDX_W-1:0]  idx_reg,   idx_next;
    logic                              valid_reg, valid_next;
    logic [7:0]                        char_reg,  char_next;
    logic                              last_reg,  last_next;

    logic [itoa_pkg::VALUE_W-1:0]      value_u;
    logic                              neg_dec;
    logic [BCD_W-1:0]                  bcd_adj;
    itoa_pkg::digit_vec_t              digits;
    logic [3:0]                        cur_digit;

    assign value_u = value;
    assign neg_dec = value_u[itoa_pkg::VALUE_W-1] && (radix_code == itoa_pkg::RADIX_DEC);

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    // The digits of the current number, one nibble each, least significant first.
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::MAX_DIGITS; i++)
        begin
            digits[i] = 4'd0;
        end
        case (radix_reg)
            itoa_pkg::RADIX_OCT:
            begin
                for (int g = 0; g < itoa_pkg::MAX_DIGITS - 1; g++)
                begin
                    digits[g] = {1'b0, mag_reg[3*g +: 3]};
                end
                digits[itoa_pkg::MAX_DIGITS-1] = {2'b00, mag_reg[31:30]};
            end
            itoa_pkg::RADIX_DEC:
            begin
                for (int d = 0; d < itoa_pkg::BCD_DIGITS; d++)
                begin
                    digits[d] = bcd_reg[4*d +: 4];
                end
            end
            itoa_pkg::RADIX_HEX:
            begin
                for (int h = 0; h < 8; h++)
                begin
                    digits[h] = mag_reg[4*h +: 4];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cur_digit = digits[idx_reg];

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        radix_next = radix_reg;
        minus_next = minus_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;

        if (cmd.load)
        begin
            // A negative decimal request is formatted as its magnitude.
            mag_next   = neg_dec ? (32'd0 - value_u) : value_u;
            bcd_next   = '0;
            radix_next = radix_code;
            minus_next = neg_dec;
            cnt_next   = '0;
        end
        if (cmd.dd_step)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[itoa_pkg::VALUE_W-1]};
            mag_next = {mag_reg[itoa_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.find)
        begin
            idx_next = itoa_pkg::lead_digit(digits);
        end
        if (cmd.emit_minus)
        begin
            valid_next = 1'b1;
            char_next  = itoa_pkg::CHAR_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            valid_next = 1'b1;
            char_next  = itoa_pkg::digit_char(cur_digit);
            last_next  = (idx_reg == '0);
            idx_next   = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            minus_reg <= 1'b0;
            radix_reg <= itoa_pkg::RADIX_OCT;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            minus_reg <= minus_next;
            radix_reg <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.dd_last  = (cnt_reg == itoa_pkg::LAST_STEP);
    assign status.minus    = minus_reg;
    assign status.idx_zero = (idx_reg == '0);

    assign char_valid = valid_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;

endmodule

// File: hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Instantiates itoa_ctrl and itoa_datapath; depends on itoa_pkg.

// A request is taken when start is high and busy is low; busy then stays high
// until the last character has been issued. Characters come out most
// significant first, one per cycle on char_code while char_valid is high, and
// the receiver must take each one in that cycle since it cannot stall the
// block. The final character carries last_char. Octal and hexadecimal requests
// keep busy high through a digit search and then while their characters are
// issued. Decimal requests first run a shift-and-add-3 binary to BCD
// conversion, then the digit search, an optional minus sign and the digits. A
// request with radix code three is accepted and gives no characters.
module integer_to_ascii_formatter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    input  logic [1:0]         radix_code,
    output logic               char_valid,
    output logic [7:0]         char_code,
    output logic               last_char
);

    itoa_pkg::ctrl_cmd_t  cmd;
    itoa_pkg::dp_status_t status;

    itoa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .radix_code (radix_code),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    itoa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix_code (radix_code),
        .cmd        (cmd),
        .status     (status),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule
